/* rtl/core/lsh_pkg.sv */
// Package with the LSH-512 constants, types and the rotate helper function.
package lsh_pkg;

	localparam int unsigned Steps = 28;
	localparam int unsigned BlockWords = 32;

	typedef logic [63:0] word_t;
	typedef logic [7:0] bfill_t;

	// Block handed from the front part to the compression engine.
	typedef struct packed {
		logic  last;
		word_t [BlockWords-1:0] words;
	} blk_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_STEP,
		ENG_FINAL,
		ENG_OUT
	} eng_state_t;

	localparam word_t IvWords [16] = '{
		64'hADD50F3C7F07094E, 64'hE3F3CEE8F9418A4F, 64'hB527ECDE5B3D0AE9, 64'h2EF6DEC68076F501,
		64'h8CB994CAE5ACA216, 64'hFBB9EAE4BBA48CC7, 64'h650A526174725FEA, 64'h1F9A61A73F8D8085,
		64'hB6607378173B539B, 64'h1BC99853B0C0B9ED, 64'hDF727FC19B182D47, 64'hDBEF360CF893A457,
		64'h4981F5E570147E80, 64'hD00C4490CA7D3E30, 64'h5D73940C0E4AE1EC, 64'h894085E2EDB2D819
	};

	localparam word_t ScFirst [8] = '{
		64'h97884283c938982a, 64'hba1fca93533e2355, 64'hc519a2e87aeb1c03, 64'h9a0fc95462af17b1,
		64'hfc3dda8ab019a82b, 64'h02825d079a895407, 64'h79f2d0a7ee06a6f7, 64'hd76d15eed9fdf5fe
	};

	localparam int unsigned GammaRot [8] = '{0, 16, 32, 48, 8, 24, 40, 56};
	localparam int unsigned SigmaPerm [16] = '{6, 4, 5, 7, 12, 15, 14, 13, 2, 0, 1, 3, 8, 11, 10, 9};
	localparam int unsigned TauPerm [16] = '{3, 2, 0, 1, 7, 4, 5, 6, 11, 10, 8, 9, 15, 12, 13, 14};

	// Rotate left by a constant amount.
	function automatic word_t rotl(input word_t x, input int unsigned r);
		word_t y;
		y = (r % 64 == 0) ? x : ((x << (r % 64)) | (x >> (64 - (r % 64))));
		return y;
	endfunction

endpackage

/* rtl/core/lsh_if.sv */
// Valid/ready channel interfaces for message words and digest words.
interface lsh_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  valid_bytes;
	logic        final_item;
	modport source (output valid, data_word, valid_bytes, final_item, input ready);
	modport sink (input valid, data_word, valid_bytes, final_item, output ready);
endinterface

interface lsh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [2:0]  digest_index;
	logic        digest_end;
	modport source (output valid, digest_word, digest_index, digest_end, input ready);
	modport sink (input valid, digest_word, digest_index, digest_end, output ready);
endinterface

/* rtl/core/lsh512_hash.sv */
// Top level of the LSH-512-512 hash block.
// Usage: message words enter on in_ch (valid/ready), 64 bits each, first
// byte in bits 7..0, with a count of valid bytes and a final flag. The
// digest leaves on out_ch as eight 64-bit words, index 0 to 7, with the
// end flag on the last word.
// The front part packs bytes into a 256-byte block register; a full block
// is handed to the engine, which runs 28 steps at one step per cycle and
// then the closing message XOR. The front part gathers the next block
// meanwhile; the remainder of a word that crosses a block border goes
// into the next block before new input is taken. A final item adds a
// padding step and the padded block's compression; the engine then sends
// the eight digest words.
// Reset clears the fill count and loads the chain value with the IV.
// When out_ch stalls the engine holds the digest word, and the front
// part keeps gathering up to one more block.
module lsh512_hash
	import lsh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lsh_in_if.sink in_ch,
	lsh_out_if.source out_ch
);

	logic blk_valid;
	logic blk_ready;
	blk_t blk;

	lsh_gather u_gather (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.blk_valid(blk_valid), .blk_ready(blk_ready), .blk(blk)
	);

	lsh_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.blk_valid(blk_valid), .blk_ready(blk_ready), .blk(blk), .out_ch(out_ch)
	);

endmodule

/* rtl/core/lsh_gather.sv */
// Front part: packs message bytes into 256-byte blocks and pads the last one.
module lsh_gather
	import lsh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lsh_in_if.sink in_ch,
	output logic blk_valid,
	input  logic blk_ready,
	output blk_t blk
);

	word_t [BlockWords-1:0] buf_q;
	bfill_t fill_q;
	logic   held_q;
	logic   pad_q;
	logic   pend_last_q;
	logic   [63:0] carry_q;
	logic   [3:0] carry_n_q;
	logic   has_carry_q;
	logic   [3:0] cnt;
	logic   [8:0] total;
	logic   take;

	// A pending block, padding or carried remainder blocks new input.
	assign in_ch.ready = !held_q && !pad_q && !has_carry_q;
	assign take = in_ch.valid && in_ch.ready;
	assign cnt = (in_ch.valid_bytes > 4'd8) ? 4'd8 : in_ch.valid_bytes;
	assign total = {1'b0, fill_q} + {5'd0, cnt};
	assign blk_valid = held_q;
	assign blk.words = buf_q;
	assign blk.last = pend_last_q;

	// Place bytes starting at a byte position; returns updated buffer.
	function automatic word_t [BlockWords-1:0] put_bytes(input word_t [BlockWords-1:0] b,
			input bfill_t pos, input logic [63:0] d, input logic [3:0] n);
		word_t [BlockWords-1:0] r;
		bfill_t p;
		r = b;
		for (int i = 0; i < 8; i++) begin
			p = pos + bfill_t'(i);
			if (i < n && (int'(pos) + i) < 256)
				r[p[7:3]][p[2:0]*8 +: 8] = d[i*8 +: 8];
		end
		return r;
	endfunction

	// Padding byte and clearing of every byte above it.
	function automatic word_t [BlockWords-1:0] pad_bytes(input word_t [BlockWords-1:0] b,
			input bfill_t pos);
		word_t [BlockWords-1:0] r;
		logic [7:0] bi;
		r = b;
		for (int i = 0; i < 256; i++) begin
			bi = 8'(i);
			if (bi == pos)
				r[i/8][(i%8)*8 +: 8] = 8'h80;
			else if (bi > pos)
				r[i/8][(i%8)*8 +: 8] = 8'h00;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			held_q <= 1'b0;
			pad_q <= 1'b0;
			pend_last_q <= 1'b0;
			has_carry_q <= 1'b0;
		end else begin
			if (held_q) begin
				// Wait for the engine to take the full block.
				if (blk_ready)
					held_q <= 1'b0;
			end else if (has_carry_q) begin
				// Remainder of a word that crossed the block border.
				buf_q <= put_bytes(buf_q, 8'd0, carry_q, carry_n_q);
				fill_q <= bfill_t'(carry_n_q);
				has_carry_q <= 1'b0;
			end else if (pad_q) begin
				buf_q <= pad_bytes(buf_q, fill_q);
				pend_last_q <= 1'b1;
				held_q <= 1'b1;
				pad_q <= 1'b0;
				fill_q <= '0;
			end else if (take) begin
				buf_q <= put_bytes(buf_q, fill_q, in_ch.data_word, cnt);
				pend_last_q <= 1'b0;
				if (total >= 9'd256) begin
					held_q <= 1'b1;
					fill_q <= '0;
					carry_q <= in_ch.data_word >> ((9'd256 - {1'b0, fill_q}) * 8);
					carry_n_q <= 4'(total - 9'd256);
					has_carry_q <= (total > 9'd256);
					pad_q <= in_ch.final_item;
				end else begin
					fill_q <= total[7:0];
					pad_q <= in_ch.final_item;
				end
			end
		end
	end

	ap_no_take_held: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> !in_ch.ready) else $error("input taken while block held");
	ap_last_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_q && !held_q && !has_carry_q) |=> (held_q && pend_last_q))
		else $error("padding did not present last block");
	ap_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(held_q) |=> fill_q == '0 || has_carry_q || $past(has_carry_q))
		else $error("fill count not reset");

endmodule

/* rtl/core/lsh_engine.sv */
// Back part: compresses one block per 28 steps and emits the digest words.
module lsh_engine
	import lsh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic blk_valid,
	output logic blk_ready,
	input  blk_t blk,
	lsh_out_if.source out_ch
);

	eng_state_t state_q, state_d;
	word_t [15:0] cv_q;
	word_t [31:0] msg_q;
	word_t [7:0] sc_q;
	logic [4:0] step_q;
	logic last_q;
	logic [2:0] oidx_q;
	word_t [15:0] sub_n, cv_x, cv_m, cv_p, m_even_f;
	word_t [7:0] sc_n;
	logic odd;

	// One step: expand, XOR, mix, permute.
	always_comb begin
		word_t a, b;
		odd = step_q[0];
		for (int l = 0; l < 16; l++) begin
			if (step_q >= 5'd2)
				sub_n[l] = odd ? (msg_q[l] + msg_q[16 + TauPerm[l]])
				               : (msg_q[16 + l] + msg_q[TauPerm[l]]);
			else
				sub_n[l] = odd ? msg_q[16 + l] : msg_q[l];
			cv_x[l] = cv_q[l] ^ sub_n[l];
		end
		for (int l = 0; l < 8; l++) begin
			a = cv_x[l];
			b = cv_x[l + 8];
			a = (odd ? rotl(a + b, 7) : rotl(a + b, 23)) ^ sc_q[l];
			b = odd ? rotl(b + a, 3) : rotl(b + a, 59);
			a = a + b;
			b = rotl(b, GammaRot[l]);
			cv_m[l] = a;
			cv_m[l + 8] = b;
			sc_n[l] = sc_q[l] + rotl(sc_q[l], 8);
		end
		for (int l = 0; l < 16; l++) begin
			cv_p[l] = cv_m[SigmaPerm[l]];
			m_even_f[l] = msg_q[16 + l] + msg_q[TauPerm[l]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ENG_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		blk_ready = 1'b0;
		case (state_q)
			ENG_IDLE: begin
				blk_ready = 1'b1;
				if (blk_valid)
					state_d = ENG_STEP;
			end
			ENG_STEP:
				if (step_q == 5'(Steps - 1))
					state_d = ENG_FINAL;
			ENG_FINAL:
				state_d = last_q ? ENG_OUT : ENG_IDLE;
			ENG_OUT:
				if (out_ch.ready && oidx_q == 3'd7)
					state_d = ENG_IDLE;
			default:
				state_d = ENG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < 16; l++)
				cv_q[l] <= IvWords[l];
			step_q <= '0;
			oidx_q <= '0;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				ENG_IDLE:
					if (blk_valid) begin
						msg_q <= blk.words;
						last_q <= blk.last;
						step_q <= '0;
						for (int l = 0; l < 8; l++)
							sc_q[l] <= ScFirst[l];
					end
				ENG_STEP: begin
					cv_q <= cv_p;
					sc_q <= sc_n;
					step_q <= step_q + 5'd1;
					for (int l = 0; l < 16; l++) begin
						if (odd) msg_q[16 + l] <= sub_n[l];
						else msg_q[l] <= sub_n[l];
					end
				end
				ENG_FINAL: begin
					for (int l = 0; l < 16; l++)
						cv_q[l] <= cv_q[l] ^ m_even_f[l];
					oidx_q <= '0;
				end
				ENG_OUT:
					if (out_ch.ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7)
							for (int l = 0; l < 16; l++)
								cv_q[l] <= IvWords[l];
					end
				default: ;
			endcase
		end
	end

	assign out_ch.valid = (state_q == ENG_OUT);
	assign out_ch.digest_word = cv_q[oidx_q] ^ cv_q[{1'b1, oidx_q}];
	assign out_ch.digest_index = oidx_q;
	assign out_ch.digest_end = (oidx_q == 3'd7);

	ap_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ENG_STEP) |-> step_q < 5'(Steps)) else $error("step overrun");
	ap_out_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ENG_OUT) |-> last_q) else $error("digest without last block");
	ap_final_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ENG_FINAL) |=> state_q != ENG_FINAL) else $error("final repeated");

endmodule

/* tb/lsh512_checker.sv */
`timescale 1ns / 1ps
// Checker for the LSH-512 hash block: predicts digest words and compares them.
module lsh512_checker
	import lsh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lsh_in_if.sink msg_ch,
	lsh_out_if.sink dig_ch,
	output int unsigned fail_count,
	output int unsigned pending_words
);

	typedef struct packed {
		word_t      word;
		logic [2:0] index;
		logic       last;
	} digest_t;

	word_t chain [16];
	word_t block_buf [32];
	int unsigned fill_bytes;
	digest_t digest_q [$];

	assign pending_words = digest_q.size();

	// Compress the current block buffer into the chain value.
	function automatic void compress_buffer();
		word_t msg [32];
		word_t sc [8];
		word_t tmp [16];
		word_t a;
		word_t b;
		int unsigned base;
		int unsigned othr;
		int unsigned al;
		int unsigned be;
		for (int i = 0; i < 32; i++) msg[i] = block_buf[i];
		for (int i = 0; i < 8; i++) sc[i] = ScFirst[i];
		for (int s = 0; s < 28; s++) begin
			base = (s % 2) ? 16 : 0;
			othr = (s % 2) ? 0 : 16;
			al = (s % 2) ? 7 : 23;
			be = (s % 2) ? 3 : 59;
			if (s >= 2) begin
				for (int l = 0; l < 16; l++) tmp[l] = msg[base + l];
				for (int l = 0; l < 16; l++) msg[base + l] = msg[othr + l] + tmp[TauPerm[l]];
			end
			for (int l = 0; l < 16; l++) chain[l] ^= msg[base + l];
			for (int l = 0; l < 8; l++) begin
				a = chain[l];
				b = chain[l + 8];
				a = rotl(a + b, al) ^ sc[l];
				b = rotl(b + a, be);
				a = a + b;
				b = rotl(b, GammaRot[l]);
				chain[l] = a;
				chain[l + 8] = b;
			end
			for (int l = 0; l < 16; l++) tmp[l] = chain[l];
			for (int l = 0; l < 16; l++) chain[l] = tmp[SigmaPerm[l]];
			for (int l = 0; l < 8; l++) sc[l] = sc[l] + rotl(sc[l], 8);
		end
		for (int l = 0; l < 16; l++) tmp[l] = msg[l];
		for (int l = 0; l < 16; l++) msg[l] = msg[16 + l] + tmp[TauPerm[l]];
		for (int l = 0; l < 16; l++) chain[l] ^= msg[l];
	endfunction

	function automatic void put_byte(int unsigned pos, logic [7:0] val);
		block_buf[pos / 8][(pos % 8) * 8 +: 8] = val;
	endfunction

	// Absorb one message transaction; on the final one, pad and queue the digest.
	function automatic void absorb(logic [63:0] data, logic [3:0] count, logic fin);
		int unsigned n;
		digest_t d;
		n = (count > 8) ? 8 : count;
		for (int i = 0; i < n; i++) begin
			put_byte(fill_bytes, data[i * 8 +: 8]);
			fill_bytes++;
			if (fill_bytes == 256) begin
				compress_buffer();
				fill_bytes = 0;
			end
		end
		if (fin) begin
			put_byte(fill_bytes, 8'h80);
			for (int i = fill_bytes + 1; i < 256; i++) put_byte(i, 8'h00);
			compress_buffer();
			for (int k = 0; k < 8; k++) begin
				d.word = chain[k] ^ chain[k + 8];
				d.index = 3'(k);
				d.last = (k == 7);
				digest_q.push_back(d);
			end
			for (int i = 0; i < 16; i++) chain[i] = IvWords[i];
			fill_bytes = 0;
		end
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("error at %0t: %s got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		fill_bytes = 0;
		for (int i = 0; i < 16; i++) chain[i] = IvWords[i];
		for (int i = 0; i < 32; i++) block_buf[i] = '0;
	end

	// Watch both channels at each rising edge.
	always @(posedge clk) begin
		digest_t e;
		if (arst_n) begin
			if (dig_ch.valid && dig_ch.ready) begin
				if (digest_q.size() == 0) begin
					report("unexpected digest transaction", dig_ch.digest_word, '0);
				end else begin
					e = digest_q.pop_front();
					if (dig_ch.digest_word !== e.word)
						report("digest_word", dig_ch.digest_word, e.word);
					if (dig_ch.digest_index !== e.index)
						report("digest_index", 64'(dig_ch.digest_index), 64'(e.index));
					if (dig_ch.digest_end !== e.last)
						report("digest_end", 64'(dig_ch.digest_end), 64'(e.last));
				end
			end
			if (msg_ch.valid && msg_ch.ready)
				absorb(msg_ch.data_word, msg_ch.valid_bytes, msg_ch.final_item);
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Testbench top: drives messages into the LSH-512 hash block and gives the verdict.
module testbench;
	import lsh_pkg::*;

	localparam int unsigned StallLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int unsigned send_idle;
	int unsigned recv_stall;
	int unsigned fail_count;
	int unsigned pending_words;
	int unsigned quiet_cycles = 0;

	lsh_in_if in_ch ();
	lsh_out_if out_ch ();

	lsh512_hash i_dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	lsh512_checker i_checker (
		.clk(clk), .arst_n(arst_n), .msg_ch(in_ch), .dig_ch(out_ch),
		.fail_count(fail_count), .pending_words(pending_words)
	);

	always #6 clk = ~clk;

	// Receiver stalls at random.
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && quiet_cycles >= StallLimit) begin
			$display("lsh512_hash: mismatch");
			$finish;
		end
	end

	// Send one message transaction, with random idle cycles before it.
	task automatic send_word(input logic [63:0] data, input logic [3:0] count, input logic fin);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_word <= data;
		in_ch.valid_bytes <= count;
		in_ch.final_item <= fin;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Send a message of nwords words, mostly full, ending with a final word of tail bytes.
	task automatic send_message(input int unsigned nwords, input logic [3:0] tail);
		for (int i = 0; i < nwords; i++) begin
			if ($urandom_range(19) == 0)
				send_word(rand_word(), 4'($urandom_range(15)), 1'b0);
			else
				send_word(rand_word(), 4'd8, 1'b0);
		end
		send_word(rand_word(), tail, 1'b1);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data_word = '0;
		in_ch.valid_bytes = '0;
		in_ch.final_item = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, field extremes, counts above eight.
		send_word('0, 4'd0, 1'b1);
		send_word('1, 4'd8, 1'b1);
		send_word('0, 4'd8, 1'b0);
		send_word('1, 4'd15, 1'b0);
		send_word(64'h0123456789abcdef, 4'd3, 1'b0);
		send_word('1, 4'd9, 1'b1);
		// Exactly one block, then 31 words and a final word of seven bytes.
		for (int i = 0; i < 32; i++) send_word(rand_word(), 4'd8, 1'b0);
		send_word(rand_word(), 4'd0, 1'b1);
		send_message(31, 4'd7);

		// Random messages across the idling phases.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 64; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 64; end
				3: begin send_idle = 37; recv_stall = 37; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			for (int m = 0; m < 4; m++) begin
				if ($urandom_range(5) == 0)
					send_message($urandom_range(40, 70), 4'($urandom_range(15)));
				else
					send_message($urandom_range(0, 6), 4'($urandom_range(15)));
			end
		end
		in_ch.valid <= 1'b0;
		@(posedge clk);

		// Drain the remaining digest words.
		while (pending_words != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("lsh512_hash: match");
		else
			$display("lsh512_hash: mismatch");
		$finish;
	end

endmodule
